>>> hdl/multi_channel_volume_fade_defines.svh
// assertion macros shared by the volume fade block
`ifndef MULTI_CHANNEL_VOLUME_FADE_DEFINES_SVH
`define MULTI_CHANNEL_VOLUME_FADE_DEFINES_SVH

// checked outside reset
`define MCVF_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define MCVF_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/mcvf_pkg.sv
// types and constants of the volume fade block
package mcvf_pkg;

   localparam int CHANNELS  = 4;
   localparam int CH_W      = 2;
   localparam int VOL_W     = 16;
   localparam int MS_W      = 16;
   localparam int PROD_W    = VOL_W + MS_W;
   localparam int ACTIVE_CH = (CHANNELS > (2 ** CH_W)) ? (2 ** CH_W) : CHANNELS;
   localparam int ACH_W     = (ACTIVE_CH > 1) ? $clog2(ACTIVE_CH) : 1;

   localparam logic [VOL_W-1:0] UNITY_VOL = VOL_W'(32768);

   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [VOL_W-1:0] cur_vol;
      logic [VOL_W-1:0] start_vol;
      logic [VOL_W-1:0] end_vol;
      logic [MS_W-1:0]  span_ms;
      logic [MS_W-1:0]  elapsed_ms;
   } entry_type;

   typedef struct packed {
      logic [CH_W-1:0]  out_channel;
      logic [VOL_W-1:0] volume;
      logic             last;
   } rsp_beat_type;

endpackage

>>> hdl/mcvf_req_if.sv
// request channel of the volume fade block
interface mcvf_req_if;
   import mcvf_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [CH_W-1:0]  channel;
   logic [VOL_W-1:0] target_volume;
   logic [MS_W-1:0]  fade_ms;
   logic [MS_W-1:0]  delta_ms;

   modport source (output valid, output op, output channel, output target_volume,
                   output fade_ms, output delta_ms, input ready);
   modport sink (input valid, input op, input channel, input target_volume,
                 input fade_ms, input delta_ms, output ready);

endinterface

>>> hdl/mcvf_rsp_if.sv
// response channel of the volume fade block
interface mcvf_rsp_if;
   import mcvf_pkg::*;

   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  out_channel;
   logic [VOL_W-1:0] volume;
   logic             last;

   modport source (output valid, output out_channel, output volume, output last,
                   input ready);
   modport sink (input valid, input out_channel, input volume, input last,
                 output ready);

endinterface

>>> hdl/mcvf_div.sv
// serial restoring divider, one quotient bit per cycle
module mcvf_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mcvf_pkg::PROD_W-1:0] dividend,
   input  logic [mcvf_pkg::MS_W-1:0]   divisor,
   output logic                      done,
   output logic [mcvf_pkg::VOL_W-1:0]  quotient
);
   import mcvf_pkg::*;

   localparam int CNT_W = $clog2(VOL_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VOL_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MS_W-1:0]  rem_ff;
   logic [VOL_W-1:0] quo_ff;
   logic [MS_W-1:0]  dvs_ff;

   logic [MS_W:0]    shifted;
   logic [MS_W:0]    diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[VOL_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[PROD_W-1:VOL_W];
         quo_ff <= dividend[VOL_W-1:0];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[MS_W-1:0] : shifted[MS_W-1:0];
         quo_ff <= {quo_ff[VOL_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/mcvf_obuf.sv
// output register between the sequencer and the response channel
module mcvf_obuf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  mcvf_pkg::rsp_beat_type     in_beat,
   output logic                       in_ready,
   mcvf_rsp_if.source                 rsp_if
);
   import mcvf_pkg::*;

   logic         valid_ff;
   rsp_beat_type beat_ff;

   assign in_ready = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_channel = beat_ff.out_channel;
   assign rsp_if.volume      = beat_ff.volume;
   assign rsp_if.last        = beat_ff.last;

endmodule

>>> hdl/multi_channel_volume_fade.sv
// per-channel linear volume fader, top level
//
// req_if carries commands as valid/ready beats. op set writes one channel: with
// fade_ms zero the target applies at once and one response beat follows; with
// fade_ms nonzero a linear fade starts from the present volume, no response.
// op tick advances every fading channel by delta_ms and gives one response
// beat per such channel in channel order, last set on the final one; a tick
// with no fading channel gives none. Sets to channels past the channel count
// are dropped.
// Channel state sits in a small synchronous RAM with a registered read port. It is
// read ahead of the update and written back once per command or channel, so
// accesses never overlap. A tick scans the channels in order; each fading channel
// passes through calc, multiply, the 16-step serial divider that forms its ramp
// value, and emit. A response beat is registered in the output buffer before it
// shows on rsp_if.
// Commands are taken one at a time; req_if.ready is high only between commands.
// A stalled rsp_if holds the sequencer at its next beat; the output register
// keeps the pending beat stable.
// Synchronous reset sets every channel to unity volume and clears all fades.
module multi_channel_volume_fade (
   input logic        clock,
   input logic        reset,
   mcvf_req_if.sink   req_if,
   mcvf_rsp_if.source rsp_if
);
   import mcvf_pkg::*;

   `include "multi_channel_volume_fade_defines.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET_WR,
      S_T_SCAN,
      S_T_CALC,
      S_T_MUL,
      S_T_DIV,
      S_EMIT
   } state_type;

   localparam logic [ACH_W-1:0] LAST_CH = ACH_W'(ACTIVE_CH - 1);

   state_type            state_ff, state_in;
   logic [ACH_W-1:0]     idx_ff, idx_in;
   logic                 tick_ff, tick_in;
   logic [VOL_W-1:0]     tgt_ff, tgt_in;
   logic [VOL_W-1:0]     vol_ff, vol_in;
   logic [VOL_W-1:0]     d_ff, d_in;
   logic [MS_W-1:0]      fade_ff, fade_in;
   logic [MS_W-1:0]      delta_ff, delta_in;
   logic [MS_W-1:0]      t_ff, t_in;
   logic                 neg_ff, neg_in;
   logic                 fin_ff, fin_in;
   logic                 last_ff, last_in;
   logic [ACTIVE_CH-1:0] fading_ff, fading_in;
   logic [ACTIVE_CH-1:0] init_ff, init_in;

   entry_type            vol_ram [ACTIVE_CH];
   entry_type            rd_data_ff;
   logic [ACH_W-1:0]     rd_addr;
   logic [ACH_W-1:0]     wr_addr;
   logic                 wr_en;
   entry_type            wr_data;

   logic                 in_range;
   logic [ACH_W-1:0]     req_ch;
   logic [VOL_W-1:0]     tgt_sat;
   logic [VOL_W-1:0]     cur_rd;
   logic [MS_W:0]        t_sum;
   logic [VOL_W-1:0]     ramp_vol;
   logic                 more;
   logic                 div_start;
   logic                 div_done;
   logic [VOL_W-1:0]     div_quo;
   logic [PROD_W-1:0]    prod;
   logic                 obuf_push;
   logic                 obuf_ready;
   rsp_beat_type         push_beat;

   assign req_if.ready = (state_ff == S_IDLE) && !reset;
   assign in_range     = (32'(req_if.channel) < ACTIVE_CH);
   assign req_ch       = req_if.channel[ACH_W-1:0];
   assign tgt_sat      = (req_if.target_volume > UNITY_VOL) ? UNITY_VOL
                                                           : req_if.target_volume;
   assign rd_addr      = (state_ff == S_IDLE) ? req_ch : idx_ff;
   assign cur_rd       = init_ff[idx_ff] ? rd_data_ff.cur_vol : UNITY_VOL;
   assign t_sum        = {1'b0, rd_data_ff.elapsed_ms} + {1'b0, delta_ff};
   assign prod         = PROD_W'(d_ff) * PROD_W'(t_ff);
   assign ramp_vol     = neg_ff ? (rd_data_ff.start_vol - div_quo)
                                : (rd_data_ff.start_vol + div_quo);
   assign div_start    = (state_ff == S_T_MUL);
   assign obuf_push    = (state_ff == S_EMIT);
   assign push_beat    = '{out_channel: CH_W'(idx_ff), volume: vol_ff, last: last_ff};

   // fading channels above the one in work
   always_comb begin
      more = 1'b0;
      for (int j = 0; j < ACTIVE_CH; j++) begin
         if (ACH_W'(j) > idx_ff) begin
            more = more | fading_ff[j];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      tick_in   = tick_ff;
      tgt_in    = tgt_ff;
      vol_in    = vol_ff;
      d_in      = d_ff;
      fade_in   = fade_ff;
      delta_in  = delta_ff;
      t_in      = t_ff;
      neg_in    = neg_ff;
      fin_in    = fin_ff;
      last_in   = last_ff;
      fading_in = fading_ff;
      init_in   = init_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid && req_if.ready) begin
               if (req_if.op == OP_TICK) begin
                  tick_in  = 1'b1;
                  delta_in = req_if.delta_ms;
                  idx_in   = '0;
                  state_in = S_T_SCAN;
               end else if (in_range) begin
                  tick_in = 1'b0;
                  idx_in  = req_ch;
                  tgt_in  = tgt_sat;
                  fade_in = req_if.fade_ms;
                  if (req_if.fade_ms == '0) begin
                     wr_en             = 1'b1;
                     wr_addr           = req_ch;
                     wr_data           = '0;
                     wr_data.cur_vol   = tgt_sat;
                     fading_in[req_ch] = 1'b0;
                     init_in[req_ch]   = 1'b1;
                     vol_in            = tgt_sat;
                     last_in           = 1'b1;
                     state_in          = S_EMIT;
                  end else begin
                     state_in = S_SET_WR;
                  end
               end
            end
         end
         S_SET_WR: begin
            wr_en              = 1'b1;
            wr_data.cur_vol    = cur_rd;
            wr_data.start_vol  = cur_rd;
            wr_data.end_vol    = tgt_ff;
            wr_data.span_ms    = fade_ff;
            wr_data.elapsed_ms = '0;
            fading_in[idx_ff]  = 1'b1;
            init_in[idx_ff]    = 1'b1;
            state_in           = S_IDLE;
         end
         S_T_SCAN: begin
            if (fading_ff[idx_ff]) begin
               state_in = S_T_CALC;
            end else if (idx_ff == LAST_CH) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + ACH_W'(1);
            end
         end
         S_T_CALC: begin
            if (t_sum >= {1'b0, rd_data_ff.span_ms}) begin
               t_in   = rd_data_ff.span_ms;
               fin_in = 1'b1;
            end else begin
               t_in   = t_sum[MS_W-1:0];
               fin_in = 1'b0;
            end
            neg_in   = (rd_data_ff.end_vol < rd_data_ff.start_vol);
            d_in     = (rd_data_ff.end_vol < rd_data_ff.start_vol)
                     ? (rd_data_ff.start_vol - rd_data_ff.end_vol)
                     : (rd_data_ff.end_vol - rd_data_ff.start_vol);
            state_in = S_T_MUL;
         end
         S_T_MUL: begin
            state_in = S_T_DIV;
         end
         S_T_DIV: begin
            if (div_done) begin
               wr_en              = 1'b1;
               wr_data.cur_vol    = ramp_vol;
               wr_data.elapsed_ms = t_ff;
               if (fin_ff) begin
                  fading_in[idx_ff] = 1'b0;
               end
               vol_in   = ramp_vol;
               last_in  = !more;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (obuf_ready) begin
               if (tick_ff && !last_ff) begin
                  idx_in   = idx_ff + ACH_W'(1);
                  state_in = S_T_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fading_ff <= '0;
         init_ff   <= '0;
         tick_ff   <= 1'b0;
         last_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         fading_ff <= fading_in;
         init_ff   <= init_in;
         tick_ff   <= tick_in;
         last_ff   <= last_in;
         idx_ff    <= idx_in;
      end
      tgt_ff   <= tgt_in;
      vol_ff   <= vol_in;
      d_ff     <= d_in;
      fade_ff  <= fade_in;
      delta_ff <= delta_in;
      t_ff     <= t_in;
      neg_ff   <= neg_in;
      fin_ff   <= fin_in;
   end

   // channel state ram
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vol_ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= vol_ram[rd_addr];
   end

   mcvf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (rd_data_ff.span_ms),
      .done     (div_done),
      .quotient (div_quo)
   );

   mcvf_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (obuf_push),
      .in_beat  (push_beat),
      .in_ready (obuf_ready),
      .rsp_if   (rsp_if)
   );

   `MCVF_CHECK(a_div_done_in_div, div_done |-> (state_ff == S_T_DIV), "divider done outside wait")
   `MCVF_CHECK(a_vol_unity, obuf_push |-> (push_beat.volume <= UNITY_VOL), "volume above unity")
   `MCVF_CHECK(a_span_nonzero, (state_ff == S_T_CALC) |-> (rd_data_ff.span_ms != '0), "zero span")
   `MCVF_CHECK_ALWAYS(a_reset_clear, reset |=> (state_ff == S_IDLE && fading_ff == '0), "reset")

endmodule
